### hw/rtl/cfd_pkg.sv
package cfd_pkg;

  // defaults for the top-level parameters
  localparam int unsigned MaxTapsDef       = 64;
  localparam int unsigned SampleWidthDef   = 16;
  localparam int unsigned CoefWidthDef     = 16;
  localparam int unsigned MaxDecimationDef = 64;

  localparam int unsigned TapIndexWidth = 6;
  localparam int unsigned CfgDataWidth  = 7;
  localparam int unsigned CfgIndexWidth = 1;

  // request kinds
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  // register indexes
  localparam logic [CfgIndexWidth-1:0] REG_DECIMATION = 1'b0;
  localparam logic [CfgIndexWidth-1:0] REG_TAP_COUNT  = 1'b1;

  localparam logic [CfgDataWidth-1:0] DecimationReset = 7'd1;
  localparam logic [CfgDataWidth-1:0] TapCountReset   = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_ACCUM,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic shift;   // new sample enters, history moves one cell down the line
    logic rotate;  // history and taps circulate one cell toward the head
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;    // start a new sum
    logic capture;  // take the product of the head cell
    logic used;     // the head cell's tap is within the tap count
  } mac_ctrl_t;

endpackage

### hw/rtl/cfd_cell.sv
module cfd_cell
  import cfd_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef,
  parameter int unsigned COEF_WIDTH   = CoefWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cell_ctrl_t                     ctrl_i,
  input  logic                           load_i,
  input  logic signed [COEF_WIDTH-1:0]   load_value_i,
  input  logic signed [SAMPLE_WIDTH-1:0] shift_i_i,
  input  logic signed [SAMPLE_WIDTH-1:0] shift_q_i,
  input  logic signed [SAMPLE_WIDTH-1:0] rot_i_i,
  input  logic signed [SAMPLE_WIDTH-1:0] rot_q_i,
  input  logic signed [COEF_WIDTH-1:0]   rot_coef_i,
  output logic signed [SAMPLE_WIDTH-1:0] hist_i_o,
  output logic signed [SAMPLE_WIDTH-1:0] hist_q_o,
  output logic signed [COEF_WIDTH-1:0]   coef_o
);

  logic signed [SAMPLE_WIDTH-1:0] hist_i_q, hist_q_q;
  logic signed [COEF_WIDTH-1:0]   coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_i_q <= '0;
      hist_q_q <= '0;
      coef_q   <= '0;
    end else begin
      priority if (ctrl_i.rotate) begin
        hist_i_q <= rot_i_i;
        hist_q_q <= rot_q_i;
        coef_q   <= rot_coef_i;
      end else if (ctrl_i.shift) begin
        hist_i_q <= shift_i_i;
        hist_q_q <= shift_q_i;
      end else if (load_i) begin
        coef_q <= load_value_i;
      end else begin
        // hold
      end
    end
  end

  assign hist_i_o = hist_i_q;
  assign hist_q_o = hist_q_q;
  assign coef_o   = coef_q;

endmodule

### hw/rtl/cfd_mac.sv
module cfd_mac
  import cfd_pkg::*;
#(
  parameter int unsigned MAX_TAPS     = MaxTapsDef,
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef,
  parameter int unsigned COEF_WIDTH   = CoefWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mac_ctrl_t                      ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] head_i_i,
  input  logic signed [SAMPLE_WIDTH-1:0] head_q_i,
  input  logic signed [COEF_WIDTH-1:0]   head_coef_i,
  output logic signed [SAMPLE_WIDTH-1:0] res_i_o,
  output logic signed [SAMPLE_WIDTH-1:0] res_q_o,
  output logic                           sat_o
);

  localparam int unsigned PW = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int unsigned AW = PW + $clog2(MAX_TAPS);

  // half an lsb of the result, upper and lower output bounds
  localparam logic signed [AW:0] Rnd =
    {{(AW - COEF_WIDTH + 2){1'b0}}, 1'b1, {(COEF_WIDTH - 2){1'b0}}};
  localparam logic signed [AW:0] MaxV =
    {{(AW - SAMPLE_WIDTH + 2){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [AW:0] MinV =
    {{(AW - SAMPLE_WIDTH + 2){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

  logic signed [PW-1:0] prod_i_q, prod_q_q;
  logic                 prod_en_q;
  logic signed [AW-1:0] acc_i_q, acc_q_q;
  logic                 sat_i, sat_q;

  // round to nearest, ties up, then clip; msb of the result flags clipping
  function automatic logic [SAMPLE_WIDTH:0] finish(input logic signed [AW-1:0] a);
    logic signed [AW:0] r;
    logic signed [AW:0] s;
    r = $signed({a[AW-1], a}) + Rnd;
    s = r >>> (COEF_WIDTH - 1);
    if (s > MaxV) begin
      finish = {1'b1, MaxV[SAMPLE_WIDTH-1:0]};
    end else if (s < MinV) begin
      finish = {1'b1, MinV[SAMPLE_WIDTH-1:0]};
    end else begin
      finish = {1'b0, s[SAMPLE_WIDTH-1:0]};
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_en_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      prod_en_q <= 1'b0;
    end else begin
      prod_en_q <= ctrl_i.capture && ctrl_i.used;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_i_q <= PW'(head_i_i) * PW'(head_coef_i);
    prod_q_q <= PW'(head_q_i) * PW'(head_coef_i);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      acc_i_q <= '0;
      acc_q_q <= '0;
    end else if (prod_en_q) begin
      acc_i_q <= acc_i_q + {{(AW - PW){prod_i_q[PW-1]}}, prod_i_q};
      acc_q_q <= acc_q_q + {{(AW - PW){prod_q_q[PW-1]}}, prod_q_q};
    end
  end

  assign {sat_i, res_i_o} = finish(acc_i_q);
  assign {sat_q, res_q_o} = finish(acc_q_q);
  assign sat_o = sat_i | sat_q;

endmodule

### hw/rtl/complex_fir_decimator.sv
// channel   direction  handshake                   payload
// in        in         in_valid_i / in_ready_o     action, sample_i/q, tap_index, tap_value
// out       out        out_valid_o / out_ready_i   out_i, out_q, saturated
// cfg       in         cfg_we_i                    cfg_index_i, cfg_data_i
//
// a load request or a filter request off the decimation phase leaves the block idle and ready
// a filter request on phase zero runs through RUN, ACCUM and DONE: history and taps
//   circulate once around the cell line past a single complex mac at the head
// reset clears history, taps and phase and sets the registers to their defaults at once; no clearing pass
// the finished result waits in its own stage while the output register is full,
//   and in_ready_o stays low only until it moves there
module complex_fir_decimator
  import cfd_pkg::*;
#(
  parameter int unsigned MAX_TAPS       = MaxTapsDef,
  parameter int unsigned SAMPLE_WIDTH   = SampleWidthDef,
  parameter int unsigned COEF_WIDTH     = CoefWidthDef,
  parameter int unsigned MAX_DECIMATION = MaxDecimationDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_q_i,
  input  logic [TapIndexWidth-1:0]       tap_index_i,
  input  logic signed [COEF_WIDTH-1:0]   tap_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] out_i_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_q_o,
  output logic                           saturated_o,
  input  logic                           cfg_we_i,
  input  logic [CfgIndexWidth-1:0]       cfg_index_i,
  input  logic [CfgDataWidth-1:0]        cfg_data_i
);

  localparam int unsigned TIW = $clog2(MAX_TAPS);
  localparam int unsigned PHW = (MAX_DECIMATION > 1) ? $clog2(MAX_DECIMATION) : 1;
  localparam int unsigned DCW = ($clog2(MAX_DECIMATION + 1) > CfgDataWidth) ?
                                $clog2(MAX_DECIMATION + 1) : CfgDataWidth;
  localparam int unsigned NCW = (TIW + 1 > CfgDataWidth) ? TIW + 1 : CfgDataWidth;
  localparam int unsigned LIW = (TIW > TapIndexWidth) ? TIW : TapIndexWidth;
  localparam logic [TIW-1:0] LastStep = TIW'(MAX_TAPS - 1);

  state_e                  state_q, state_d;
  logic [TIW-1:0]          step_q;
  logic [PHW-1:0]          phase_q;
  logic [DCW-1:0]          phase_inc;
  logic [CfgDataWidth-1:0] decimation_q, tap_count_q;

  logic accept, is_filter, emit, load_out;
  cell_ctrl_t cell_ctrl;
  mac_ctrl_t  mac_ctrl;

  logic signed [SAMPLE_WIDTH-1:0] hist_i [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] hist_q [MAX_TAPS];
  logic signed [COEF_WIDTH-1:0]   coef   [MAX_TAPS];

  logic signed [SAMPLE_WIDTH-1:0] res_i, res_q;
  logic                           res_sat;

  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_i_q, out_q_q;
  logic                           out_sat_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_filter  = (action_i == ACT_FILTER);
  assign emit       = accept && is_filter && (phase_q == '0);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decimation_q <= DecimationReset;
      tap_count_q  <= TapCountReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DECIMATION: decimation_q <= cfg_data_i;
        REG_TAP_COUNT:  tap_count_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // decimation phase; a zero or oversized setting wraps like its clamped value
  assign phase_inc = DCW'(phase_q) + DCW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (accept && is_filter) begin
      if (phase_inc >= DCW'(decimation_q) || phase_inc >= DCW'(MAX_DECIMATION)) begin
        phase_q <= '0;
      end else begin
        phase_q <= phase_inc[PHW-1:0];
      end
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        step_q <= '0;
      end else if (state_q == ST_RUN) begin
        step_q <= step_q + TIW'(1);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (emit) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_q == LastStep) begin
          state_d = ST_ACCUM;
        end
      end
      ST_ACCUM: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign cell_ctrl.shift  = accept && is_filter;
  assign cell_ctrl.rotate = (state_q == ST_RUN);

  // a zero tap count still uses the first tap
  assign mac_ctrl.clear   = emit;
  assign mac_ctrl.capture = (state_q == ST_RUN);
  assign mac_ctrl.used    = (NCW'(step_q) < NCW'(tap_count_q)) || (step_q == '0);

  // cell line: cell k holds x[n-k] and h[k] between requests
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    localparam int unsigned Nxt = (k + 1) % MAX_TAPS;
    logic signed [SAMPLE_WIDTH-1:0] sh_i, sh_q;
    logic                           load;

    if (k == 0) begin : g_head
      assign sh_i = sample_i_i;
      assign sh_q = sample_q_i;
    end else begin : g_body
      assign sh_i = hist_i[k-1];
      assign sh_q = hist_q[k-1];
    end

    assign load = accept && (action_i == ACT_LOAD) && (LIW'(tap_index_i) == LIW'(k));

    cfd_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .load_i       (load),
      .load_value_i (tap_value_i),
      .shift_i_i    (sh_i),
      .shift_q_i    (sh_q),
      .rot_i_i      (hist_i[Nxt]),
      .rot_q_i      (hist_q[Nxt]),
      .rot_coef_i   (coef[Nxt]),
      .hist_i_o     (hist_i[k]),
      .hist_q_o     (hist_q[k]),
      .coef_o       (coef[k])
    );
  end

  cfd_mac #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mac_ctrl),
    .head_i_i    (hist_i[0]),
    .head_q_i    (hist_q[0]),
    .head_coef_i (coef[0]),
    .res_i_o     (res_i),
    .res_q_o     (res_q),
    .sat_o       (res_sat)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_i_q   <= res_i;
      out_q_q   <= res_q;
      out_sat_q <= res_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_i_o     = out_i_q;
  assign out_q_o     = out_q_q;
  assign saturated_o = out_sat_q;

  // an output request starts one full pass around the line
  a_emit_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (state_q == ST_RUN) && (step_q == '0))
    else $error("filter pass did not start");

  // a finished result waits while the output register is still taken
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && out_valid_q && !out_ready_i |=> (state_q == ST_DONE))
    else $error("result overwrote a pending output");

  // the clip flag only comes with a value at a rail
  a_sat_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (out_i_o == {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}}) ||
      (out_i_o == {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}}) ||
      (out_q_o == {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}}) ||
      (out_q_o == {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}}))
    else $error("clip flag without a clipped value");

endmodule
